// ===== hdl/directory_entry_sorter_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of the directory entry sorter.
// ----------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_SORTER_CORE_MACROS_SVH
`define DIRECTORY_ENTRY_SORTER_CORE_MACROS_SVH

// Assertion that is checked only outside of reset.
`define DES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define DES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/des_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_pkg
// Types and constants shared by the directory entry sorter modules.
// ----------------------------------------------------------------------------
package des_pkg;

  localparam int unsigned HEAD_W     = 64;
  localparam int unsigned TAIL_W     = 40;
  localparam int unsigned NAME_BYTES = 13;
  localparam int unsigned NAME_W     = HEAD_W + TAIL_W;

  // One stored record: name bytes and the directory flag.
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [TAIL_W-1:0] tail;
    logic              dir;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  // Port enables of the record store.
  typedef struct packed {
    logic we;
    logic re_a;
    logic re_b;
  } store_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_SWAP,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

endpackage

// ===== hdl/directory_entry_sorter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directory_entry_sorter_core
// Collects directory records and emits them sorted, directories first.
// ----------------------------------------------------------------------------
// Records are loaded one per cycle into a single memory until a request marked
// last_entry arrives; up to MAX_ENTRIES are held and later ones are dropped.
// The held records are then gnome sorted in place and streamed out, and no
// request is taken until the last record has left the memory. Each sort step
// reads a pair (ST_SORT_RD) and compares it (ST_SORT_CMP); a swapped pair
// adds ST_SORT_SWAP, because the memory has one write port and a swap writes
// two entries. Each record is output by a memory read, then the output
// register, and the output can stall.
// ----------------------------------------------------------------------------
module directory_entry_sorter_core #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [des_pkg::HEAD_W-1:0] name_head_i,
  input  logic [des_pkg::TAIL_W-1:0] name_tail_i,
  input  logic                       is_dir_i,
  input  logic                       last_entry_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [des_pkg::HEAD_W-1:0] sorted_head_o,
  output logic [des_pkg::TAIL_W-1:0] sorted_tail_o,
  output logic                       sorted_dir_o,
  output logic                       last_result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  des_pkg::state_e     state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    pos_q, pos_d;

  logic                out_valid_q, out_valid_d;
  des_pkg::rec_t       out_rec_q;
  logic                out_last_q;
  logic                out_load;
  logic                out_last_d;

  des_pkg::store_ctl_t st_ctl;
  logic [IDX_W-1:0]    waddr;
  des_pkg::rec_t       wdata;
  logic [IDX_W-1:0]    raddr_a;
  logic [IDX_W-1:0]    raddr_b;
  des_pkg::rec_t       rdata_a;
  des_pkg::rec_t       rdata_b;
  logic                swap;

  logic                in_acc;
  logic                full;
  logic                out_free;
  des_pkg::rec_t       in_rec;

  des_store #(
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (st_ctl),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  des_cmp u_cmp (
    .a_i    (rdata_a),
    .b_i    (rdata_b),
    .swap_o (swap)
  );

  assign in_stall_o = (state_q != des_pkg::ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CNT_W'(MAX_ENTRIES));
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_rec.head = name_head_i;
  assign in_rec.tail = name_tail_i;
  assign in_rec.dir  = is_dir_i;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    st_ctl     = '0;
    waddr      = pos_q;
    wdata      = rdata_b;
    raddr_a    = pos_q;
    raddr_b    = pos_q + IDX_W'(1);
    out_load   = 1'b0;
    out_last_d = 1'b0;

    case (state_q)
      des_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            st_ctl.we = 1'b1;
            waddr     = cnt_q[IDX_W-1:0];
            wdata     = in_rec;
            cnt_d     = cnt_q + CNT_W'(1);
          end
          if (last_entry_i) begin
            pos_d = '0;
            // A lone record needs no sorting.
            if (cnt_q == '0) begin
              state_d = des_pkg::ST_EMIT_RD;
            end else begin
              state_d = des_pkg::ST_SORT_RD;
            end
          end
        end
      end

      des_pkg::ST_SORT_RD: begin
        st_ctl.re_a = 1'b1;
        st_ctl.re_b = 1'b1;
        state_d     = des_pkg::ST_SORT_CMP;
      end

      des_pkg::ST_SORT_CMP: begin
        if (swap) begin
          st_ctl.we = 1'b1;
          waddr     = pos_q;
          wdata     = rdata_b;
          state_d   = des_pkg::ST_SORT_SWAP;
        end else if ((CNT_W'(pos_q) + CNT_W'(2)) < cnt_q) begin
          pos_d   = pos_q + IDX_W'(1);
          state_d = des_pkg::ST_SORT_RD;
        end else begin
          pos_d   = '0;
          state_d = des_pkg::ST_EMIT_RD;
        end
      end

      des_pkg::ST_SORT_SWAP: begin
        st_ctl.we = 1'b1;
        waddr     = pos_q + IDX_W'(1);
        wdata     = rdata_a;
        if (pos_q != '0) begin
          pos_d = pos_q - IDX_W'(1);
        end
        state_d = des_pkg::ST_SORT_RD;
      end

      des_pkg::ST_EMIT_RD: begin
        st_ctl.re_a = 1'b1;
        state_d     = des_pkg::ST_EMIT_OUT;
      end

      des_pkg::ST_EMIT_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_d = ((CNT_W'(pos_q) + CNT_W'(1)) == cnt_q);
          if (out_last_d) begin
            cnt_d   = '0;
            pos_d   = '0;
            state_d = des_pkg::ST_LOAD;
          end else begin
            pos_d   = pos_q + IDX_W'(1);
            state_d = des_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = des_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= des_pkg::ST_LOAD;
      cnt_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rec_q  <= rdata_a;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sorted_head_o = out_rec_q.head;
  assign sorted_tail_o = out_rec_q.tail;
  assign sorted_dir_o  = out_rec_q.dir;
  assign last_result_o = out_last_q;

endmodule

// ===== hdl/des_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_store
// Record memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module des_store #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk_i,
  input  des_pkg::store_ctl_t            ctl_i,
  input  logic [$clog2(DEPTH)-1:0]       waddr_i,
  input  des_pkg::rec_t                  wdata_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]       raddr_b_i,
  output des_pkg::rec_t                  rdata_a_o,
  output des_pkg::rec_t                  rdata_b_o
);

  des_pkg::rec_t mem [DEPTH];
  des_pkg::rec_t rdata_a_q;
  des_pkg::rec_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re_a) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (ctl_i.re_b) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== hdl/des_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_cmp
// Ordering test for two neighboring records: directories first, then names
// by unsigned byte value up to the first zero byte.
// ----------------------------------------------------------------------------
module des_cmp (
  input  des_pkg::rec_t a_i,
  input  des_pkg::rec_t b_i,
  output logic          swap_o
);

  logic [des_pkg::NAME_W-1:0]     name_a;
  logic [des_pkg::NAME_W-1:0]     name_b;
  logic [des_pkg::NAME_BYTES-1:0] stop;
  logic [des_pkg::NAME_BYTES-1:0] gt;
  logic                           name_gt;

  assign name_a = {a_i.head, a_i.tail};
  assign name_b = {b_i.head, b_i.tail};

  // Each byte position decides when its bytes differ or the name ends there.
  always_comb begin
    for (int i = 0; i < des_pkg::NAME_BYTES; i++) begin
      stop[i] = (name_a[des_pkg::NAME_W-1-8*i -: 8] != name_b[des_pkg::NAME_W-1-8*i -: 8])
                || (name_a[des_pkg::NAME_W-1-8*i -: 8] == 8'd0);
      gt[i]   = name_a[des_pkg::NAME_W-1-8*i -: 8] > name_b[des_pkg::NAME_W-1-8*i -: 8];
    end
  end

  // The first deciding byte wins.
  always_comb begin
    name_gt = 1'b0;
    for (int i = des_pkg::NAME_BYTES - 1; i >= 0; i--) begin
      if (stop[i]) begin
        name_gt = gt[i];
      end
    end
  end

  assign swap_o = (a_i.dir != b_i.dir) ? (b_i.dir & ~a_i.dir) : name_gt;

endmodule

// ===== hdl/des_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// des_checker
// Port-level checks for the directory entry sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "directory_entry_sorter_core_macros.svh"

module des_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       last_entry_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [des_pkg::HEAD_W-1:0] sorted_head_o,
  input logic [des_pkg::TAIL_W-1:0] sorted_tail_o,
  input logic                       sorted_dir_o,
  input logic                       last_result_o
);

  logic                    in_take;
  logic                    out_held;
  logic [des_pkg::REC_W:0] out_word;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {sorted_head_o, sorted_tail_o, sorted_dir_o, last_result_o};

  // A stalled result keeps its contents.
  `DES_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_word), "stalled result changed")

  // The request that closes a set starts sorting, so loading pauses.
  `DES_ASSERT(a_last_blocks, in_take && last_entry_i |=> in_stall_o, "request taken while sorting")

  // While a run is still being emitted, no new request is taken.
  `DES_ASSERT(a_emit_blocks, out_valid_o && !last_result_o |-> in_stall_o, "input open mid-run")

  // Reset leaves no result pending.
  `DES_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind directory_entry_sorter_core des_checker u_des_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the directory entry sorter core.
// ----------------------------------------------------------------------------
// A driver feeds directory records from a queue of pending requests. Each
// accepted request updates a local copy of the listing. A request marked
// last_entry sorts that copy the same way the block does and queues the
// sorted records. A monitor takes every output record and compares it with
// the oldest queued record. Both sides idle in random bursts. The receiver
// also holds off once for a long stretch, so that the core backs up onto its
// input. Listings are mostly small. Two listings reach the capacity, and one
// of them overflows it with a dropped record that carries last_entry.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned TARGET_ITEMS = 410;
  localparam int unsigned QUIET_ITEMS  = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned IDLE_LIMIT   = 40000;
  localparam int unsigned MAX_REPORTS  = 100;

  // One directory record together with its end-of-listing marker. The same
  // type carries both requests and the expected output records.
  typedef struct packed {
    logic [des_pkg::HEAD_W-1:0] head;
    logic [des_pkg::TAIL_W-1:0] tail;
    logic                       dir;
    logic                       last;
  } listing_item_t;

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [des_pkg::HEAD_W-1:0] name_head_i  = '0;
  logic [des_pkg::TAIL_W-1:0] name_tail_i  = '0;
  logic                       is_dir_i     = 1'b0;
  logic                       last_entry_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [des_pkg::HEAD_W-1:0] sorted_head_o;
  logic [des_pkg::TAIL_W-1:0] sorted_tail_o;
  logic                       sorted_dir_o;
  logic                       last_result_o;

  directory_entry_sorter_core #(
    .MAX_ENTRIES(CAPACITY)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_head_i  (name_head_i),
    .name_tail_i  (name_tail_i),
    .is_dir_i     (is_dir_i),
    .last_entry_i (last_entry_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sorted_head_o(sorted_head_o),
    .sorted_tail_o(sorted_tail_o),
    .sorted_dir_o (sorted_dir_o),
    .last_result_o(last_result_o)
  );

  always #5 clk_i = ~clk_i;

  listing_item_t pending_items[$];
  listing_item_t sorted_expect[$];
  des_pkg::rec_t listing[$];
  listing_item_t drive_item;

  int unsigned total_items;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned listings_closed = 0;
  int unsigned error_count     = 0;
  int unsigned report_count    = 0;
  int unsigned idle_cycles     = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;

  // True when record a has to be placed after record b.
  function automatic bit ranks_after(des_pkg::rec_t a, des_pkg::rec_t b);
    logic [des_pkg::NAME_W-1:0] name_a;
    logic [des_pkg::NAME_W-1:0] name_b;
    logic [7:0]                 byte_a;
    logic [7:0]                 byte_b;
    if (a.dir != b.dir) begin
      return b.dir;
    end
    name_a = {a.head, a.tail};
    name_b = {b.head, b.tail};
    for (int i = 0; i < des_pkg::NAME_BYTES; i++) begin
      byte_a = name_a[des_pkg::NAME_W-1-8*i -: 8];
      byte_b = name_b[des_pkg::NAME_W-1-8*i -: 8];
      if (byte_a != byte_b) begin
        return byte_a > byte_b;
      end
      // The name ends at the first zero byte; what follows does not count.
      if (byte_a == 8'h00) begin
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // Gnome sort of the held listing, then queue every record in order.
  task automatic close_listing();
    int unsigned   pos;
    des_pkg::rec_t swap_rec;
    listing_item_t rec_out;
    pos = 0;
    while (pos + 1 < listing.size()) begin
      if (ranks_after(listing[pos], listing[pos+1])) begin
        swap_rec       = listing[pos];
        listing[pos]   = listing[pos+1];
        listing[pos+1] = swap_rec;
        if (pos > 0) begin
          pos--;
        end
      end else begin
        pos++;
      end
    end
    foreach (listing[k]) begin
      rec_out.head = listing[k].head;
      rec_out.tail = listing[k].tail;
      rec_out.dir  = listing[k].dir;
      rec_out.last = (k == listing.size() - 1);
      sorted_expect.push_back(rec_out);
    end
    listing.delete();
    listings_closed++;
  endtask

  task automatic load_listing_entry(listing_item_t req);
    des_pkg::rec_t held;
    held.head = req.head;
    held.tail = req.tail;
    held.dir  = req.dir;
    // Records past the capacity are dropped, but their marker still counts.
    if (listing.size() < CAPACITY) begin
      listing.push_back(held);
    end
    if (req.last) begin
      close_listing();
    end
  endtask

  task automatic push_item(logic [des_pkg::NAME_W-1:0] name, logic dir, logic last);
    listing_item_t req;
    req.head = name[des_pkg::NAME_W-1 -: des_pkg::HEAD_W];
    req.tail = name[des_pkg::TAIL_W-1:0];
    req.dir  = dir;
    req.last = last;
    pending_items.push_back(req);
  endtask

  // Mostly short names over a tiny alphabet so that ties and prefixes are
  // common, plus full random names and names with bytes after a zero.
  function automatic logic [des_pkg::NAME_W-1:0] random_name();
    logic [des_pkg::NAME_W-1:0] name;
    logic [7:0]                 char;
    int unsigned                kind;
    int unsigned                len;
    kind = $urandom_range(0, 9);
    name = '0;
    if (kind < 2) begin
      name[103:72] = $urandom;
      name[71:40]  = $urandom;
      name[39:8]   = $urandom;
      name[7:0]    = 8'($urandom_range(0, 255));
      return name;
    end
    len = (kind < 7) ? $urandom_range(1, 3) : $urandom_range(0, 13);
    for (int i = 0; i < des_pkg::NAME_BYTES; i++) begin
      if (i < len) begin
        char = (kind < 7) ? 8'h41 + 8'($urandom_range(0, 2)) : 8'($urandom_range(1, 255));
      end else if (i > len && kind == 9) begin
        char = 8'($urandom_range(0, 255));
      end else begin
        char = 8'h00;
      end
      name[des_pkg::NAME_W-1-8*i -: 8] = char;
    end
    return name;
  endfunction

  task automatic push_random_listing(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      push_item(random_name(), 1'($urandom_range(0, 1)), i == count - 1);
    end
  endtask

  function automatic int unsigned random_listing_size();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(9, 24);
    end
    return $urandom_range(1, 8);
  endfunction

  task automatic report_mismatch(string field, logic [des_pkg::HEAD_W-1:0] want,
                                 logic [des_pkg::HEAD_W-1:0] got);
    error_count++;
    if (report_count < MAX_REPORTS) begin
      report_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  task automatic check_sorted_record();
    listing_item_t want;
    if (sorted_expect.size() == 0) begin
      error_count++;
      if (report_count < MAX_REPORTS) begin
        report_count++;
        $display("%0t: unexpected record, expected none, actual %h %h %b %b", $time,
                 sorted_head_o, sorted_tail_o, sorted_dir_o, last_result_o);
      end
    end else begin
      want = sorted_expect.pop_front();
      if (sorted_head_o !== want.head) begin
        report_mismatch("sorted_head", want.head, sorted_head_o);
      end
      if (sorted_tail_o !== want.tail) begin
        report_mismatch("sorted_tail", des_pkg::HEAD_W'(want.tail),
                        des_pkg::HEAD_W'(sorted_tail_o));
      end
      if (sorted_dir_o !== want.dir) begin
        report_mismatch("sorted_dir", des_pkg::HEAD_W'(want.dir),
                        des_pkg::HEAD_W'(sorted_dir_o));
      end
      if (last_result_o !== want.last) begin
        report_mismatch("last_result", des_pkg::HEAD_W'(want.last),
                        des_pkg::HEAD_W'(last_result_o));
      end
    end
    results_checked++;
  endtask

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      name_head_i  <= '0;
      name_tail_i  <= '0;
      is_dir_i     <= 1'b0;
      last_entry_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        load_listing_entry(drive_item);
        items_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 8) - 1;
          in_valid_i <= 1'b0;
        end else begin
          drive_item = pending_items.pop_front();
          name_head_i  <= drive_item.head;
          name_tail_i  <= drive_item.tail;
          is_dir_i     <= drive_item.dir;
          last_entry_i <= drive_item.last;
          in_valid_i   <= 1'b1;
        end
      end
    end
  end

  // Output monitor and receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_sorted_record();
        // Hold off once in the middle of a listing so the core backs up.
        if (!hold_done && results_checked >= 30 && !last_result_o) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (pending_items.size() > QUIET_ITEMS && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted request or record.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d records outstanding", $time,
                 idle_cycles, sorted_expect.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // A listing of a single record.
    push_item({des_pkg::NAME_W{1'b1}}, 1'b1, 1'b1);
    // Extremes, ties, unsigned byte order, embedded zeros, full-width names.
    push_item('0, 1'b0, 1'b0);
    push_item({des_pkg::NAME_W{1'b1}}, 1'b0, 1'b0);
    push_item('0, 1'b1, 1'b0);
    push_item({"ABC", 80'h0}, 1'b0, 1'b0);
    push_item({"ABC", 80'h0}, 1'b1, 1'b0);
    push_item({"MMMMMMMMMMMM", 8'h02}, 1'b0, 1'b0);
    push_item({"MMMMMMMMMMMM", 8'h01}, 1'b0, 1'b0);
    push_item({"AB", 8'h00, "X", 72'h0}, 1'b0, 1'b0);
    push_item({"AB", 8'h00, "Y", 72'h0}, 1'b0, 1'b0);
    push_item({8'h80, 96'h0}, 1'b0, 1'b0);
    push_item({8'h7F, 96'h0}, 1'b0, 1'b0);
    push_item({"MMMMMMMMMMMM", 8'h01}, 1'b1, 1'b0);
    push_item({"ABC", 80'h0}, 1'b0, 1'b0);
    push_item({"ZZZZZZZZZZZZZ"}, 1'b1, 1'b1);
    // Two-record listings, one reversed by name and one by the flag.
    push_item({"B", 96'h0}, 1'b0, 1'b0);
    push_item({"A", 96'h0}, 1'b0, 1'b1);
    push_item({"B", 96'h0}, 1'b0, 1'b0);
    push_item({"A", 96'h0}, 1'b1, 1'b1);

    // Random listings; one fills the store exactly, one overflows it.
    push_random_listing(CAPACITY);
    while (pending_items.size() < 200) begin
      push_random_listing(random_listing_size());
    end
    push_random_listing(CAPACITY + 2);
    while (pending_items.size() < TARGET_ITEMS) begin
      push_random_listing(random_listing_size());
    end
    total_items = pending_items.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < total_items) begin
      @(posedge clk_i);
    end
    while (sorted_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d records in %0d listings and checked %0d sorted records,",
             items_accepted, listings_closed, results_checked);
    $display("including a full store, an overflowing one and a long output hold-off.");
    if (error_count == 0 && sorted_expect.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
